@@ design/bhpq_pkg.sv @@
package bhpq_pkg;

  localparam int KeyWidth    = 32;
  localparam int CountWidth  = 7;
  localparam int DefCapacity = 64;

  typedef logic signed [KeyWidth-1:0] key_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PEEK,
    S_POP_TOP,
    S_POP_LOAD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_PICK,
    S_DN_CMP
  } state_t;

  // datapath micro-ops, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_PUSH_INIT,
    DP_REJECT_FULL,
    DP_EMPTY,
    DP_NOOP_DONE,
    DP_RD_TOP,
    DP_PEEK_DONE,
    DP_POP_ONLY,
    DP_POP_TOP,
    DP_POP_LOAD,
    DP_UP_RD,
    DP_UP_MOVE,
    DP_UP_DONE,
    DP_DN_RDL,
    DP_DN_RDR,
    DP_DN_LONE,
    DP_DN_CMPR,
    DP_DN_MOVE,
    DP_DN_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;      // no keys held
    logic full;       // count at capacity
    logic one_left;   // exactly one key held
    logic at_root;    // hole index is zero
    logic up_move;    // moving key ranks before parent read back
    logic has_left;   // left child of hole exists
    logic has_right;  // right child of hole exists
    logic dn_move;    // best child ranks before moving key
  } dp_stat_t;

  // true when key a must sit above key b
  function automatic logic ranks_before(logic max_first, key_t a, key_t b);
    return max_first ? (a > b) : (a < b);
  endfunction

endpackage

@@ design/binary_heap_priority_queue.sv @@
// Binary heap priority queue, one result per command, strobed by out_valid.
// A push sifts up from the new leaf and a pop sifts down from the root, at most log2(CAPACITY) levels;
//   peek reads the root; reject, empty and no-op answer straight from idle.
// Throughput: one command at a time; busy stays high while a sift walks the heap,
// set by the single read port of the heap memory. The receiver cannot stall.
// Reset (rst_n low, synchronous): count 0, min-first order, no result pending.
module binary_heap_priority_queue #(
  parameter int CAPACITY = bhpq_pkg::DefCapacity
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_start,
  output logic                                  in_busy,
  input  logic [1:0]                            in_opcode,
  input  logic signed [bhpq_pkg::KeyWidth-1:0]  in_key_in,
  output logic                                  out_valid,
  output logic signed [bhpq_pkg::KeyWidth-1:0]  out_key_out,
  output logic [1:0]                            out_status,
  output logic [bhpq_pkg::CountWidth-1:0]       out_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_max_first
);

  bhpq_pkg::dp_cmd_t  cmd;
  bhpq_pkg::dp_stat_t stat;
  logic               idle;

  assign in_busy   = !idle;
  assign cfg_ready = idle;

  // sequencer
  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_start  (in_start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .idle      (idle)
  );

  // heap memory and registers
  bhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_key_in     (in_key_in),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_max_first (cfg_max_first),
    .out_valid     (out_valid),
    .out_key_out   (out_key_out),
    .out_status    (out_status),
    .out_count     (out_count)
  );

endmodule

@@ design/bhpq_ctrl.sv @@
module bhpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  logic [1:0]          in_opcode,
  input  bhpq_pkg::dp_stat_t  stat,
  output bhpq_pkg::dp_cmd_t   cmd,
  output logic                idle
);

  bhpq_pkg::state_t state_r, state_nxt;
  bhpq_pkg::opcode_t op;

  assign op   = bhpq_pkg::opcode_t'(in_opcode);
  assign idle = (state_r == bhpq_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (in_start) begin
          case (op)
            bhpq_pkg::OP_PUSH: if (!stat.full)  state_nxt = bhpq_pkg::S_UP_RD;
            bhpq_pkg::OP_POP:  if (!stat.empty) state_nxt = bhpq_pkg::S_POP_TOP;
            bhpq_pkg::OP_PEEK: if (!stat.empty) state_nxt = bhpq_pkg::S_PEEK;
            default:           state_nxt = bhpq_pkg::S_IDLE;
          endcase
        end
      end
      bhpq_pkg::S_PEEK:     state_nxt = bhpq_pkg::S_IDLE;
      bhpq_pkg::S_POP_TOP:
        state_nxt = stat.one_left ? bhpq_pkg::S_IDLE : bhpq_pkg::S_POP_LOAD;
      bhpq_pkg::S_POP_LOAD: state_nxt = bhpq_pkg::S_DN_RDL;
      bhpq_pkg::S_UP_RD:
        state_nxt = stat.at_root ? bhpq_pkg::S_IDLE : bhpq_pkg::S_UP_CMP;
      bhpq_pkg::S_UP_CMP:
        state_nxt = stat.up_move ? bhpq_pkg::S_UP_RD : bhpq_pkg::S_IDLE;
      bhpq_pkg::S_DN_RDL:
        state_nxt = stat.has_left ? bhpq_pkg::S_DN_RDR : bhpq_pkg::S_IDLE;
      bhpq_pkg::S_DN_RDR:
        state_nxt = stat.has_right ? bhpq_pkg::S_DN_PICK : bhpq_pkg::S_DN_CMP;
      bhpq_pkg::S_DN_PICK:  state_nxt = bhpq_pkg::S_DN_CMP;
      bhpq_pkg::S_DN_CMP:
        state_nxt = stat.dn_move ? bhpq_pkg::S_DN_RDL : bhpq_pkg::S_IDLE;
      default:              state_nxt = bhpq_pkg::S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op = bhpq_pkg::DP_NOP;
    case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (in_start) begin
          case (op)
            bhpq_pkg::OP_PUSH:
              cmd.op = stat.full ? bhpq_pkg::DP_REJECT_FULL : bhpq_pkg::DP_PUSH_INIT;
            bhpq_pkg::OP_POP, bhpq_pkg::OP_PEEK:
              cmd.op = stat.empty ? bhpq_pkg::DP_EMPTY : bhpq_pkg::DP_RD_TOP;
            default: cmd.op = bhpq_pkg::DP_NOOP_DONE;
          endcase
        end
      end
      bhpq_pkg::S_PEEK:     cmd.op = bhpq_pkg::DP_PEEK_DONE;
      bhpq_pkg::S_POP_TOP:
        cmd.op = stat.one_left ? bhpq_pkg::DP_POP_ONLY : bhpq_pkg::DP_POP_TOP;
      bhpq_pkg::S_POP_LOAD: cmd.op = bhpq_pkg::DP_POP_LOAD;
      bhpq_pkg::S_UP_RD:
        cmd.op = stat.at_root ? bhpq_pkg::DP_UP_DONE : bhpq_pkg::DP_UP_RD;
      bhpq_pkg::S_UP_CMP:
        cmd.op = stat.up_move ? bhpq_pkg::DP_UP_MOVE : bhpq_pkg::DP_UP_DONE;
      bhpq_pkg::S_DN_RDL:
        cmd.op = stat.has_left ? bhpq_pkg::DP_DN_RDL : bhpq_pkg::DP_DN_DONE;
      bhpq_pkg::S_DN_RDR:
        cmd.op = stat.has_right ? bhpq_pkg::DP_DN_RDR : bhpq_pkg::DP_DN_LONE;
      bhpq_pkg::S_DN_PICK:  cmd.op = bhpq_pkg::DP_DN_CMPR;
      bhpq_pkg::S_DN_CMP:
        cmd.op = stat.dn_move ? bhpq_pkg::DP_DN_MOVE : bhpq_pkg::DP_DN_DONE;
      default:              cmd.op = bhpq_pkg::DP_NOP;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/bhpq_dp.sv @@
module bhpq_dp #(
  parameter int CAPACITY = bhpq_pkg::DefCapacity
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bhpq_pkg::dp_cmd_t                     cmd,
  output bhpq_pkg::dp_stat_t                    stat,
  input  logic signed [bhpq_pkg::KeyWidth-1:0]  in_key_in,
  input  logic                                  cfg_we,
  input  logic                                  cfg_max_first,
  output logic                                  out_valid,
  output logic signed [bhpq_pkg::KeyWidth-1:0]  out_key_out,
  output logic [1:0]                            out_status,
  output logic [bhpq_pkg::CountWidth-1:0]       out_count
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = AW + 2;

  // heap storage, one write and one registered read per cycle
  bhpq_pkg::key_t mem [CAPACITY];
  bhpq_pkg::key_t rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  bhpq_pkg::key_t wr_data;

  logic [CW-1:0]  count_r, count_nxt;
  logic           max_first_r;
  bhpq_pkg::key_t key_r, key_nxt;        // key being sifted
  logic [AW-1:0]  idx_r, idx_nxt;        // hole position
  bhpq_pkg::key_t best_r, best_nxt;      // better child value
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  bhpq_pkg::key_t top_r, top_nxt;        // popped root

  logic                         out_valid_r, out_valid_nxt;
  bhpq_pkg::key_t               out_key_r, out_key_nxt;
  bhpq_pkg::status_t            out_status_r, out_status_nxt;

  logic [AW-1:0]  parent;
  logic [XW-1:0]  left_x, right_x;
  logic [AW-1:0]  last_idx;

  // tree index arithmetic
  assign parent   = AW'((idx_r - 1'b1) >> 1);
  assign left_x   = {1'b0, idx_r, 1'b1};
  assign right_x  = left_x + 1'b1;
  assign last_idx = AW'(count_r - 1'b1);

  // status toward the controller
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.one_left  = (count_r == CW'(1));
  assign stat.at_root   = (idx_r == '0);
  assign stat.up_move   = bhpq_pkg::ranks_before(max_first_r, key_r, rd_data_r);
  assign stat.has_left  = (left_x < XW'(count_r));
  assign stat.has_right = (right_x < XW'(count_r));
  assign stat.dn_move   = bhpq_pkg::ranks_before(max_first_r, best_r, key_r);

  // micro-op decode
  always_comb begin
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = key_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    top_nxt        = top_r;
    out_valid_nxt  = 1'b0;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    case (cmd.op)
      bhpq_pkg::DP_PUSH_INIT: begin
        key_nxt   = in_key_in;
        idx_nxt   = AW'(count_r);
        count_nxt = count_r + 1'b1;
      end
      bhpq_pkg::DP_REJECT_FULL: begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = '0;
        out_status_nxt = bhpq_pkg::ST_FULL;
      end
      bhpq_pkg::DP_EMPTY: begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = '0;
        out_status_nxt = bhpq_pkg::ST_EMPTY;
      end
      bhpq_pkg::DP_NOOP_DONE: begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = '0;
        out_status_nxt = bhpq_pkg::ST_OK;
      end
      bhpq_pkg::DP_RD_TOP: rd_addr = '0;
      bhpq_pkg::DP_PEEK_DONE: begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = rd_data_r;
        out_status_nxt = bhpq_pkg::ST_OK;
      end
      bhpq_pkg::DP_POP_ONLY: begin
        count_nxt      = count_r - 1'b1;
        out_valid_nxt  = 1'b1;
        out_key_nxt    = rd_data_r;
        out_status_nxt = bhpq_pkg::ST_OK;
      end
      bhpq_pkg::DP_POP_TOP: begin
        top_nxt   = rd_data_r;
        count_nxt = count_r - 1'b1;
        rd_addr   = last_idx;
      end
      bhpq_pkg::DP_POP_LOAD: begin
        key_nxt = rd_data_r;
        idx_nxt = '0;
      end
      bhpq_pkg::DP_UP_RD: rd_addr = parent;
      bhpq_pkg::DP_UP_MOVE: begin
        // parent drops into the hole, hole climbs
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = parent;
      end
      bhpq_pkg::DP_UP_DONE: begin
        wr_en          = 1'b1;
        out_valid_nxt  = 1'b1;
        out_key_nxt    = '0;
        out_status_nxt = bhpq_pkg::ST_OK;
      end
      bhpq_pkg::DP_DN_RDL: rd_addr = left_x[AW-1:0];
      bhpq_pkg::DP_DN_RDR: begin
        best_nxt     = rd_data_r;
        best_idx_nxt = left_x[AW-1:0];
        rd_addr      = right_x[AW-1:0];
      end
      bhpq_pkg::DP_DN_LONE: begin
        best_nxt     = rd_data_r;
        best_idx_nxt = left_x[AW-1:0];
      end
      bhpq_pkg::DP_DN_CMPR: begin
        // right child wins only if strictly better
        if (bhpq_pkg::ranks_before(max_first_r, rd_data_r, best_r)) begin
          best_nxt     = rd_data_r;
          best_idx_nxt = right_x[AW-1:0];
        end
      end
      bhpq_pkg::DP_DN_MOVE: begin
        // child rises into the hole, hole descends
        wr_en   = 1'b1;
        wr_data = best_r;
        idx_nxt = best_idx_r;
      end
      bhpq_pkg::DP_DN_DONE: begin
        wr_en          = 1'b1;
        out_valid_nxt  = 1'b1;
        out_key_nxt    = top_r;
        out_status_nxt = bhpq_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // heap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      max_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_first_r <= cfg_max_first;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    top_r        <= top_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_key_out = out_key_r;
  assign out_status  = out_status_r;
  assign out_count   = bhpq_pkg::CountWidth'(count_r);

endmodule

@@ tb/binary_heap_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module binary_heap_priority_queue_tb;

  localparam int Cap = bhpq_pkg::DefCapacity;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 255;

  // one expected result beat
  typedef struct {
    bhpq_pkg::key_t                  key;
    bhpq_pkg::status_t               status;
    logic [bhpq_pkg::CountWidth-1:0] count;
  } heap_result_t;

  // heap mirror: predicts every result, then checks them in order
  class heap_scoreboard;
    bhpq_pkg::key_t slots[Cap];
    int unsigned    fill;
    bit             max_first;
    heap_result_t   pending[$];
    int errors, n_push, n_full, n_pop, n_peek, n_empty, n_nop, n_checked, n_cfg;

    function new();
      fill = 0;
      max_first = 1'b0;
    endfunction

    // true when key a belongs above key b in the current order
    function bit sits_above(bhpq_pkg::key_t a, bhpq_pkg::key_t b);
      return max_first ? (a > b) : (a < b);
    endfunction

    function void swap_slots(int unsigned i, int unsigned j);
      bhpq_pkg::key_t t;
      t = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    function void note_config(bit v);
      max_first = v;
      n_cfg++;
    endfunction

    function void note_command(bhpq_pkg::opcode_t op, bhpq_pkg::key_t key);
      heap_result_t r;
      int unsigned idx, parent, left, right, pick;
      r.key = '0;
      r.status = bhpq_pkg::ST_OK;
      case (op)
        bhpq_pkg::OP_PUSH: begin
          n_push++;
          if (fill >= Cap) begin
            r.status = bhpq_pkg::ST_FULL;
            n_full++;
          end else begin
            slots[fill] = key;
            idx = fill;
            fill++;
            // sift up while strictly ahead of the parent
            while (idx > 0) begin
              parent = (idx - 1) / 2;
              if (!sits_above(slots[idx], slots[parent])) break;
              swap_slots(idx, parent);
              idx = parent;
            end
          end
        end
        bhpq_pkg::OP_POP, bhpq_pkg::OP_PEEK: begin
          if (op == bhpq_pkg::OP_POP) n_pop++;
          else n_peek++;
          if (fill == 0) begin
            r.status = bhpq_pkg::ST_EMPTY;
            n_empty++;
          end else begin
            r.key = slots[0];
            if (op == bhpq_pkg::OP_POP) begin
              fill--;
              slots[0] = slots[fill];
              idx = 0;
              // sift down; right child wins only when strictly ahead of left
              while (2 * idx + 1 < fill) begin
                left = 2 * idx + 1;
                right = left + 1;
                pick = left;
                if (right < fill && sits_above(slots[right], slots[left])) pick = right;
                if (!sits_above(slots[pick], slots[idx])) break;
                swap_slots(idx, pick);
                idx = pick;
              end
            end
          end
        end
        default: n_nop++;
      endcase
      r.count = fill[bhpq_pkg::CountWidth-1:0];
      pending = {pending, r};
    endfunction

    function void check_result(bhpq_pkg::key_t key, logic [1:0] status,
                               logic [bhpq_pkg::CountWidth-1:0] count);
      heap_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: key_out %0d status %0d count %0d",
               key, status, count);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (key !== e.key) begin
        $error("key_out: expected %0d, got %0d", e.key, key);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_start = 1'b0;
  logic                            in_busy;
  logic [1:0]                      in_opcode = bhpq_pkg::OP_NONE;
  bhpq_pkg::key_t                  in_key_in = '0;
  logic                            out_valid;
  bhpq_pkg::key_t                  out_key_out;
  logic [1:0]                      out_status;
  logic [bhpq_pkg::CountWidth-1:0] out_count;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_max_first = 1'b0;

  heap_scoreboard sb = new();

  binary_heap_priority_queue #(.CAPACITY(Cap)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_start     (in_start),
    .in_busy      (in_busy),
    .in_opcode    (in_opcode),
    .in_key_in    (in_key_in),
    .out_valid    (out_valid),
    .out_key_out  (out_key_out),
    .out_status   (out_status),
    .out_count    (out_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_max_first(cfg_max_first)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor; the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_key_out, out_status, out_count);
  end

  // present one command and hold it until the block takes the beat
  task automatic send_cmd(bhpq_pkg::opcode_t op, bhpq_pkg::key_t key);
    in_start  <= 1'b1;
    in_opcode <= op;
    in_key_in <= key;
    forever begin
      @(posedge clk);
      if (in_busy === 1'b0) break;
    end
    sb.note_command(op, key);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending until every expected result is back
  task automatic drain();
    in_start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(bit v);
    drain();
    cfg_valid     <= 1'b1;
    cfg_max_first <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready === 1'b1) break;
    end
    cfg_valid <= 1'b0;
    sb.note_config(v);
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small range gives lots of ties, plus the extremes and full-width noise
  function automatic bhpq_pkg::key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return bhpq_pkg::key_t'($urandom_range(0, 16)) - 8;
    if (r < 45) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return bhpq_pkg::key_t'($urandom());
  endfunction

  initial begin
    bit filling, calm;
    bit order_plan[RandPhases];
    int r, wait_cycles;
    bhpq_pkg::opcode_t op;

    order_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty heap, extremes, ties, no-op, drain past empty
    send_cmd(bhpq_pkg::OP_POP, 32'sd7);
    send_cmd(bhpq_pkg::OP_PEEK, -32'sd7);
    send_cmd(bhpq_pkg::OP_NONE, 32'sh5a5a_a5a5);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sh8000_0000);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sd0);
    send_cmd(bhpq_pkg::OP_PUSH, -32'sd1);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sd5);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sd5);
    send_cmd(bhpq_pkg::OP_PEEK, 32'sd0);
    send_cmd(bhpq_pkg::OP_NONE, -32'sd1);
    repeat (7) send_cmd(bhpq_pkg::OP_POP, 32'sd0);
    idle_for(1);
    write_order(1'b1);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sh8000_0000);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_cmd(bhpq_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_cmd(bhpq_pkg::OP_PEEK, 32'sd0);
    send_cmd(bhpq_pkg::OP_POP, 32'sd0);
    send_cmd(bhpq_pkg::OP_POP, 32'sd0);

    // random phases, each under one order setting; the heap is carried across
    filling = 1'b1;
    calm = 1'b0;
    for (int ph = 0; ph < RandPhases; ph++) begin
      write_order(order_plan[ph]);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // swing between filling to capacity and draining to empty
        if (filling && sb.fill == Cap && $urandom_range(0, 2) == 0) filling = 1'b0;
        else if (!filling && sb.fill == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 5) op = bhpq_pkg::OP_NONE;
        else if (r < 15) op = bhpq_pkg::OP_PEEK;
        else if (r < 30) op = filling ? bhpq_pkg::OP_POP : bhpq_pkg::OP_PUSH;
        else op = filling ? bhpq_pkg::OP_PUSH : bhpq_pkg::OP_POP;
        send_cmd(op, pick_key());
        idle_for(pick_gap(calm));
      end
    end

    // wind down
    in_start <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("covered %0d pushes (%0d refused on a full heap), %0d pops, %0d peeks, %0d no-ops",
             sb.n_push, sb.n_full, sb.n_pop, sb.n_peek, sb.n_nop);
    $display("%0d reads of an empty heap, %0d order writes, %0d results checked",
             sb.n_empty, sb.n_cfg, sb.n_checked);
    if (sb.errors == 0) begin
      $display("[binary_heap_priority_queue] OK");
    end else begin
      $display("[binary_heap_priority_queue] ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("[binary_heap_priority_queue] ERROR");
    $finish;
  end

endmodule
